// ===== rtl/sabn_pkg.sv =====
package sabn_pkg;

   localparam int MAX_AXES_DEF = 8;
   localparam int RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_RESET = 4'd4;

   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 32;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_DUP_AXIS  = 3'd1;
   localparam logic [2:0] ERR_ZERO_STEP = 3'd2;
   localparam logic [2:0] ERR_AXIS_OOR  = 3'd3;
   localparam logic [2:0] ERR_NEG_LEN   = 3'd4;

   typedef struct packed {
      logic               first_of_slice;
      logic signed [3:0]  axis;
      logic signed [31:0] start_index;
      logic signed [31:0] end_index;
      logic signed [31:0] stride;
      logic [30:0]        dim_size;
   } sabn_req_type;

   typedef struct packed {
      logic [2:0]         axis_out;
      logic [30:0]        norm_start;
      logic signed [31:0] norm_end;
      logic signed [31:0] stride_out;
      logic [30:0]        out_size;
      logic [2:0]         error_code;
   } sabn_rsp_type;

endpackage

// ===== rtl/sabn_div.sv =====
module sabn_div
   import sabn_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;

   // One restoring step per cycle: shift in the next dividend bit, try the subtract.
   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/slice_axis_bound_normalizer_core.sv =====
// A beat rejected at the front (axis, duplicate or zero step) goes from ST_IDLE straight to ST_DONE,
// an empty axis passes ST_CLAMP first, any other beat runs ST_CLAMP, ST_DIFF, ST_NUM, ST_DIV and ST_WAIT.
// A new beat is taken only once the last has left ST_DONE; the 33 restoring steps of the divider set the pace.
// The result register frees the input side while a result waits on rsp_stall.
// Synchronous reset sets tensor_rank to 4, clears the used-axis mask and empties the output.
module slice_axis_bound_normalizer_core
   import sabn_pkg::*;
#(
   parameter int MAX_AXES = MAX_AXES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sabn_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sabn_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [RANK_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLAMP = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_NUM   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [RANK_W-1:0]   rank_ff;
   logic [MAX_AXES-1:0] mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sabn_rsp_type        rsp_ff;
   sabn_req_type        req_ff, req_in;
   sabn_rsp_type        res_ff, res_in;
   logic [31:0]         d_ff, d_in;
   logic signed [33:0]  diff_ff, diff_in;
   logic signed [33:0]  num_ff, num_in;
   logic                rsp_load;
   logic                div_start;
   logic                div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [DIV_NUM_W-1:0] div_num;
   logic [33:0]         mag_w;

   logic [6:0]          rank_ext, rank_max, rank_eff;
   logic signed [6:0]   ax_ext, ax_norm;
   logic                in_range;
   logic [MAX_AXES-1:0] one_w, bit_w, base_mask;
   logic                dup;
   logic [2:0]          acc_err;

   logic                neg;
   logic signed [32:0]  st_w, en_w, dim_w, lim_w, s_sum, e_sum, neg_w, start_w, end_w;
   logic signed [33:0]  st34, en34, dm1;

   // Axis wrap, range, duplicate and zero-step check on the incoming beat.
   always_comb begin
      rank_ext  = {3'b000, rank_ff};
      rank_max  = 7'(MAX_AXES);
      rank_eff  = (rank_ext > rank_max) ? rank_max : rank_ext;
      ax_ext    = {{3{req_data.axis[3]}}, req_data.axis};
      ax_norm   = req_data.axis[3] ? ax_ext + $signed(rank_eff) : ax_ext;
      in_range  = !ax_norm[6] && ({1'b0, ax_norm[5:0]} < rank_eff);
      one_w     = MAX_AXES'(1);
      bit_w     = one_w << ax_norm[5:0];
      base_mask = req_data.first_of_slice ? '0 : mask_ff;
      dup       = |(base_mask & bit_w);
      priority if (!in_range) begin
         acc_err = ERR_AXIS_OOR;
      end else if (dup) begin
         acc_err = ERR_DUP_AXIS;
      end else if (req_data.stride == 32'sd0) begin
         acc_err = ERR_ZERO_STEP;
      end else begin
         acc_err = ERR_NONE;
      end
   end

   // Start and end clamping, plus the operands for the difference, numerator and divider.
   always_comb begin
      neg     = req_ff.stride[31];
      st_w    = {req_ff.start_index[31], req_ff.start_index};
      en_w    = {req_ff.end_index[31], req_ff.end_index};
      dim_w   = {2'b00, req_ff.dim_size};
      lim_w   = neg ? dim_w - 33'sd1 : dim_w;
      neg_w   = neg ? -33'sd1 : 33'sd0;
      s_sum   = st_w + dim_w;
      e_sum   = en_w + dim_w;
      if (st_w < 33'sd0) begin
         start_w = (s_sum > 33'sd0) ? s_sum : 33'sd0;
      end else begin
         start_w = (st_w < lim_w) ? st_w : lim_w;
      end
      if (en_w < 33'sd0) begin
         end_w = (e_sum > neg_w) ? e_sum : neg_w;
      end else begin
         end_w = (en_w < dim_w) ? en_w : dim_w;
      end
      st34  = $signed({3'b000, res_ff.norm_start});
      en34  = $signed({{2{res_ff.norm_end[31]}}, res_ff.norm_end});
      dm1   = $signed({2'b00, d_ff}) - 34'sd1;
      mag_w = num_ff[33] ? 34'(-num_ff) : 34'(num_ff);
   end

   assign div_num = mag_w[DIV_NUM_W-1:0];

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      d_in         = d_ff;
      diff_in      = diff_ff;
      num_in       = num_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in            = req_data;
               mask_in           = base_mask | (in_range ? bit_w : '0);
               res_in.axis_out   = in_range ? ax_norm[2:0] : 3'd0;
               res_in.norm_start = '0;
               res_in.norm_end   = '0;
               res_in.stride_out = req_data.stride;
               res_in.out_size   = '0;
               res_in.error_code = acc_err;
               state_in          = (acc_err != ERR_NONE) ? ST_DONE : ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            d_in = neg ? 32'(-req_ff.stride) : 32'(req_ff.stride);
            if (req_ff.dim_size == '0) begin
               state_in = ST_DONE;
            end else begin
               res_in.norm_start = start_w[30:0];
               res_in.norm_end   = end_w[31:0];
               state_in          = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = neg ? st34 - en34 : en34 - st34;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            num_in   = diff_ff + dm1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (num_ff[33] && (div_quo != '0)) begin
                  res_in.error_code = ERR_NEG_LEN;
               end else begin
                  res_in.out_size = div_quo[30:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   sabn_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rank_ff      <= RANK_RESET;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            rank_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      d_ff    <= d_in;
      diff_ff <= diff_in;
      num_ff  <= num_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_size_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code == ERR_NONE || rsp_data.out_size == '0))
      else $error("nonzero length on a flagged beat");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code <= ERR_NEG_LEN))
      else $error("error code out of range");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside the wait state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while one is in work");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)))
      else $error("result register overwritten");

endmodule
